[rtl/core/length_framed_byte_deframer_assert.svh]
// Assertion macros for the deframer. Every macro samples on clk and is
// held off while rst_n is low.
`ifndef LENGTH_FRAMED_BYTE_DEFRAMER_ASSERT_SVH
`define LENGTH_FRAMED_BYTE_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset.
`define LDF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("deframer invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define LDF_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer implication violated");

`else

`define LDF_ASSERT_ALWAYS(label, cond)
`define LDF_ASSERT_IMPLY(label, ante, cons)

`endif

`endif

[rtl/core/ldf_pkg.sv]
`default_nettype none

package ldf_pkg;

    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int MIN_LEN     = 5;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'h5A;
    localparam logic [BYTE_W-1:0] TAIL_RESET = 8'hA5;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEAD = 2'd0,
        REG_TAIL = 2'd1
    } cfg_reg_t;

    // Queued received byte, front to back
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } rx_xact_t;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  index;
        logic              last;
        logic              status;
    } result_t;

    // Scan engine states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_HEAD,
        ST_CHK_HEAD,
        ST_CHK_LEN,
        ST_CHK_TAIL,
        ST_SUM,
        ST_CHK_SUM,
        ST_EMIT,
        ST_ERR,
        ST_DONE
    } scan_state_t;

endpackage

`default_nettype wire

[rtl/core/length_framed_byte_deframer.sv]
// Each byte waits in a 4-entry input queue, then is appended, every buffered position is scanned
// and the scan is closed; a waiting head also closes the scan.
// A complete frame of length L is checked for length, tail and checksum, then gives one result
// per cycle, or one error, while the output is not stalled.
// Results leave through one output register; a result is visible in the cycle after emission.
// Reset: head 0x5A, tail 0xA5, buffer empty, queue empty; buffer contents are not cleared.
`default_nettype none

module length_framed_byte_deframer #(
    parameter int MAX_FRAME = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ldf_pkg::BYTE_W-1:0]    rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ldf_pkg::BYTE_W-1:0]         out_byte,
    output logic [ldf_pkg::IDX_W-1:0]          out_index,
    output logic                               out_last,
    output logic                               out_status,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ldf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ldf_pkg::BYTE_W-1:0]    cfg_data
);
    import ldf_pkg::*;

    logic [BYTE_W-1:0] head_byte;
    logic [BYTE_W-1:0] tail_byte;
    rx_xact_t          q_xact;
    logic              q_pop;
    logic              push_valid;
    result_t           push_res;
    logic              push_ready;

    // Input queue and configuration registers
    ldf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head_byte (head_byte),
        .tail_byte (tail_byte),
        .q_out     (q_xact),
        .q_pop     (q_pop)
    );

    // Frame buffer and scan engine
    ldf_scan #(
        .MAX_FRAME (MAX_FRAME)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_byte  (head_byte),
        .tail_byte  (tail_byte),
        .q_in       (q_xact),
        .q_pop      (q_pop),
        .push_valid (push_valid),
        .push_res   (push_res),
        .push_ready (push_ready)
    );

    // Result register
    ldf_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_res   (push_res),
        .push_ready (push_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_index  (out_index),
        .out_last   (out_last),
        .out_status (out_status)
    );

endmodule

`default_nettype wire

[rtl/core/ldf_front.sv]
`default_nettype none

module ldf_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ldf_pkg::BYTE_W-1:0]    rx_byte,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ldf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ldf_pkg::BYTE_W-1:0]    cfg_data,
    output logic [ldf_pkg::BYTE_W-1:0]         head_byte,
    output logic [ldf_pkg::BYTE_W-1:0]         tail_byte,
    output ldf_pkg::rx_xact_t                  q_out,
    input  wire logic                          q_pop
);
    import ldf_pkg::*;

    logic [BYTE_W-1:0] head_reg;
    logic [BYTE_W-1:0] tail_reg;
    logic [BYTE_W-1:0] q_data_reg [QUEUE_DEPTH];
    logic [QAW-1:0]    wr_ptr_reg;
    logic [QAW-1:0]    rd_ptr_reg;
    logic [QAW:0]      count_reg;
    logic [QAW:0]      count_next;
    logic              push;
    logic              pop;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;
    assign head_byte = head_reg;
    assign tail_byte = tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= HEAD_RESET;
            tail_reg <= TAIL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HEAD: head_reg <= cfg_data;
                REG_TAIL: tail_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // Queue handshake
    assign in_stall    = (count_reg == (QAW+1)'(QUEUE_DEPTH));
    assign push        = in_valid && !in_stall;
    assign pop         = q_pop && (count_reg != '0);
    assign q_out.valid = (count_reg != '0);
    assign q_out.data  = q_data_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QAW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QAW+1)'(1);
        end
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
        end
    end

    // Hold queued bytes
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[wr_ptr_reg] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ldf_scan.sv]
`default_nettype none

module ldf_scan #(
    parameter int MAX_FRAME = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [ldf_pkg::BYTE_W-1:0] head_byte,
    input  wire logic [ldf_pkg::BYTE_W-1:0] tail_byte,
    input  wire ldf_pkg::rx_xact_t          q_in,
    output logic                            q_pop,
    output logic                            push_valid,
    output ldf_pkg::result_t                push_res,
    input  wire logic                       push_ready
);
    import ldf_pkg::*;

    `include "length_framed_byte_deframer_assert.svh"

    localparam int AW = $clog2(MAX_FRAME);
    localparam int PW = $clog2(MAX_FRAME + 1);
    localparam int SW = PW + 1;

    scan_state_t       state_reg, state_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [PW-1:0]     fill_reg, fill_next;
    logic [PW-1:0]     n_reg, n_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [PW-1:0]     keep_reg, keep_next;
    logic [PW-1:0]     len_reg, len_next;
    logic [PW-1:0]     k_reg, k_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BYTE_W-1:0] rdata_reg;
    logic [BYTE_W-1:0] store_mem [MAX_FRAME];

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [PW-1:0]     n_start;
    logic [SW-1:0]     pos_w;
    logic [SW-1:0]     len_w;
    logic [SW-1:0]     rd_len_w;
    logic              len_bad;
    logic              room;
    logic              advance;
    logic              emit_last;

    // Map a buffer offset onto the circular store
    function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] base,
                                              input logic [SW-1:0] off);
        logic [SW-1:0] sum;
        logic [SW-1:0] res;
        sum = SW'(base) + off;
        res = (sum >= SW'(MAX_FRAME)) ? (sum - SW'(MAX_FRAME)) : sum;
        return res[AW-1:0];
    endfunction

    assign n_start   = (fill_reg >= PW'(MAX_FRAME)) ? '0 : fill_reg;
    assign pos_w     = SW'(pos_reg);
    assign len_w     = SW'(len_reg);
    assign rd_len_w  = SW'(rdata_reg);
    assign len_bad   = (rdata_reg < BYTE_W'(MIN_LEN)) || (rdata_reg > BYTE_W'(MAX_FRAME));
    assign room      = (cnt_reg < CNT_W'(MAX_RESULTS));
    assign advance   = !room || push_ready;
    assign emit_last = (k_reg == (len_reg - PW'(3)));

    // Next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        fill_next  = fill_reg;
        n_next     = n_reg;
        pos_next   = pos_reg;
        keep_next  = keep_reg;
        len_next   = len_reg;
        k_next     = k_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        wr_en      = 1'b0;
        wr_addr    = addr_of(base_reg, SW'(n_start));
        rd_addr    = addr_of(base_reg, pos_w);
        q_pop      = 1'b0;
        push_valid = 1'b0;
        push_res   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // Append the next byte and restart the scan
                if (q_in.valid)
                begin
                    q_pop      = 1'b1;
                    wr_en      = 1'b1;
                    n_next     = n_start + PW'(1);
                    keep_next  = n_start + PW'(1);
                    pos_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_RD_HEAD;
                end
            end

            ST_RD_HEAD:
            begin
                if (pos_reg >= n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_addr    = addr_of(base_reg, pos_w);
                    state_next = ST_CHK_HEAD;
                end
            end

            ST_CHK_HEAD:
            begin
                if (rdata_reg != head_byte)
                begin
                    pos_next   = pos_reg + PW'(1);
                    state_next = ST_RD_HEAD;
                end
                else if ((pos_w + SW'(1)) >= SW'(n_reg))
                begin
                    keep_next  = pos_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_addr    = addr_of(base_reg, pos_w + SW'(1));
                    state_next = ST_CHK_LEN;
                end
            end

            ST_CHK_LEN:
            begin
                // Drop heads with an impossible length, wait on short ones
                if (len_bad)
                begin
                    pos_next   = pos_reg + PW'(1);
                    state_next = ST_RD_HEAD;
                end
                else if ((pos_w + rd_len_w) > SW'(n_reg))
                begin
                    keep_next  = pos_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    len_next   = PW'(rdata_reg);
                    rd_addr    = addr_of(base_reg, pos_w + rd_len_w - SW'(1));
                    state_next = ST_CHK_TAIL;
                end
            end

            ST_CHK_TAIL:
            begin
                if (rdata_reg != tail_byte)
                begin
                    pos_next   = pos_reg + PW'(1);
                    state_next = ST_RD_HEAD;
                end
                else
                begin
                    // Head and length bytes are known, start summing at the type byte
                    sum_next   = head_byte + BYTE_W'(len_reg);
                    k_next     = PW'(2);
                    rd_addr    = addr_of(base_reg, pos_w + SW'(2));
                    state_next = ST_SUM;
                end
            end

            ST_SUM:
            begin
                sum_next = sum_reg + rdata_reg;
                if (emit_last)
                begin
                    rd_addr    = addr_of(base_reg, pos_w + len_w - SW'(2));
                    state_next = ST_CHK_SUM;
                end
                else
                begin
                    k_next  = k_reg + PW'(1);
                    rd_addr = addr_of(base_reg, pos_w + SW'(k_reg) + SW'(1));
                end
            end

            ST_CHK_SUM:
            begin
                if (rdata_reg == sum_reg)
                begin
                    k_next     = PW'(2);
                    rd_addr    = addr_of(base_reg, pos_w + SW'(2));
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_ERR;
                end
            end

            ST_EMIT:
            begin
                // Hold the read address until the result is taken
                rd_addr         = addr_of(base_reg, pos_w + SW'(k_reg));
                push_valid      = room;
                push_res.data   = rdata_reg;
                push_res.index  = IDX_W'(k_reg - PW'(2));
                push_res.last   = emit_last;
                push_res.status = 1'b0;
                if (advance)
                begin
                    if (room)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (emit_last)
                    begin
                        pos_next   = pos_reg + len_reg;
                        state_next = ST_RD_HEAD;
                    end
                    else
                    begin
                        k_next  = k_reg + PW'(1);
                        rd_addr = addr_of(base_reg, pos_w + SW'(k_reg) + SW'(1));
                    end
                end
            end

            ST_ERR:
            begin
                push_valid      = room;
                push_res.data   = '0;
                push_res.index  = '0;
                push_res.last   = 1'b1;
                push_res.status = 1'b1;
                if (advance)
                begin
                    if (room)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    pos_next   = pos_reg + len_reg;
                    state_next = ST_RD_HEAD;
                end
            end

            ST_DONE:
            begin
                // Drop the scanned prefix
                base_next  = addr_of(base_reg, SW'(keep_reg));
                fill_next  = n_reg - keep_reg;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            base_reg  <= '0;
            fill_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Scan payload registers
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        pos_reg  <= pos_next;
        keep_reg <= keep_next;
        len_reg  <= len_next;
        k_reg    <= k_next;
        sum_reg  <= sum_next;
    end

    // Frame buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= q_in.data;
        end
        rdata_reg <= store_mem[rd_addr];
    end

    `LDF_ASSERT_ALWAYS(a_fill_range, fill_reg < PW'(MAX_FRAME))
    `LDF_ASSERT_ALWAYS(a_base_range, base_reg < AW'(MAX_FRAME - 1) || base_reg == AW'(MAX_FRAME - 1))
    `LDF_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= CNT_W'(MAX_RESULTS))
    `LDF_ASSERT_IMPLY(a_push_state, push_valid, state_reg == ST_EMIT || state_reg == ST_ERR)
    `LDF_ASSERT_IMPLY(a_pos_bound, state_reg != ST_IDLE, pos_reg <= n_reg)

endmodule

`default_nettype wire

[rtl/core/ldf_out.sv]
`default_nettype none

module ldf_out (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push_valid,
    input  wire ldf_pkg::result_t           push_res,
    output logic                            push_ready,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [ldf_pkg::BYTE_W-1:0]      out_byte,
    output logic [ldf_pkg::IDX_W-1:0]       out_index,
    output logic                            out_last,
    output logic                            out_status
);
    import ldf_pkg::*;

    logic    out_valid_reg;
    result_t res_reg;

    // Take a new result when the register is empty or being drained
    assign push_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push_ready)
        begin
            out_valid_reg <= push_valid;
        end
    end

    // Hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            res_reg <= push_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = res_reg.data;
    assign out_index  = res_reg.index;
    assign out_last   = res_reg.last;
    assign out_status = res_reg.status;

endmodule

`default_nettype wire

[verif/length_framed_byte_deframer_tb.sv]
`timescale 1ns / 1ps

module length_framed_byte_deframer_tb;

    import ldf_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_FRAME    = 32;
    // Worst case: a full buffer rescan per queued byte plus a full frame of results
    localparam int SETTLE_CYCLES = 1000;
    localparam int CYCLE_LIMIT   = 2000000;

    // Register indexes that map to no register; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_BAD_TAIL,
        FRAME_CUT
    } frame_kind_t;

    // Frame buffer model and the queue of result transactions it predicts
    class frame_checker;
        logic [BYTE_W-1:0] store_model [MAX_FRAME];
        int unsigned       fill;
        logic [BYTE_W-1:0] head_val;
        logic [BYTE_W-1:0] tail_val;
        result_t           pending_results [$];
        int                step_count;
        int                errors;

        function new();
            fill     = 0;
            head_val = HEAD_RESET;
            tail_val = TAIL_RESET;
            errors   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
            if (idx == REG_HEAD)
                head_val = data;
            else if (idx == REG_TAIL)
                tail_val = data;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void add_expected(logic [BYTE_W-1:0] data, int unsigned idx,
                                   logic last, logic status);
            result_t r;
            if (step_count >= MAX_RESULTS)
                return;
            r.data   = data;
            r.index  = IDX_W'(idx);
            r.last   = last;
            r.status = status;
            pending_results.push_back(r);
            step_count++;
        endfunction

        // Append one accepted byte and rescan the buffer for complete frames
        function void note_byte(logic [BYTE_W-1:0] rx);
            int unsigned       n;
            int unsigned       pos;
            int unsigned       keep;
            int unsigned       len;
            int unsigned       k;
            logic [BYTE_W-1:0] sum;
            n = fill;
            if (n >= MAX_FRAME)
                n = 0;
            store_model[n] = rx;
            n++;
            keep = n;
            pos = 0;
            step_count = 0;
            while (pos < n) begin
                if (store_model[pos] != head_val) begin
                    pos++;
                    continue;
                end
                // Head without its length byte yet: hold it
                if (pos + 1 >= n) begin
                    keep = pos;
                    break;
                end
                len = store_model[pos + 1];
                if (len < MIN_LEN || len > MAX_FRAME) begin
                    pos++;
                    continue;
                end
                if (pos + len > n) begin
                    keep = pos;
                    break;
                end
                // Wrong tail: drop only the head and resume at the next byte
                if (store_model[pos + len - 1] != tail_val) begin
                    pos++;
                    continue;
                end
                sum = '0;
                for (k = 0; k < len - 2; k++)
                    sum += store_model[pos + k];
                if (sum == store_model[pos + len - 2]) begin
                    for (k = 2; k <= len - 3; k++)
                        add_expected(store_model[pos + k], k - 2, k == len - 3, 1'b0);
                end else begin
                    add_expected('0, 0, 1'b1, 1'b1);
                end
                pos += len;
            end
            // Shift the kept tail of the buffer to the front
            if (keep < n) begin
                for (k = 0; k < n - keep; k++)
                    store_model[k] = store_model[keep + k];
                fill = n - keep;
            end else begin
                fill = 0;
            end
        endfunction

        function void report(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, byte %0h index %0d last %0b status %0b",
                         $time, got.data, got.index, got.last, got.status);
                return;
            end
            want = pending_results.pop_front();
            if (got.data !== want.data)
                report("out_byte", want.data, got.data);
            if (got.index !== want.index)
                report("out_index", want.index, got.index);
            if (got.last !== want.last)
                report("out_last", want.last, got.last);
            if (got.status !== want.status)
                report("out_status", want.status, got.status);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic [BYTE_W-1:0]    out_byte;
    logic [IDX_W-1:0]     out_index;
    logic                 out_last;
    logic                 out_status;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    frame_checker      frame_chk;
    logic [BYTE_W-1:0] tx_q [$];
    logic [BYTE_W-1:0] cur_head;
    logic [BYTE_W-1:0] cur_tail;
    int                in_gap_max;
    int                out_stall_max;
    int                bytes_sent;
    int                cycle_count;

    length_framed_byte_deframer #(
        .MAX_FRAME(MAX_FRAME)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_index (out_index),
        .out_last  (out_last),
        .out_status(out_status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Append one frame for the current head and tail, optionally corrupted
    function automatic void add_frame(int len, frame_kind_t kind, bit extremes);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int                k;
        sum = cur_head + 8'(len);
        tx_q.push_back(cur_head);
        tx_q.push_back(8'(len));
        for (k = 2; k < len - 2; k++) begin
            b = extremes ? (k[0] ? 8'hFF : 8'h00) : 8'($urandom);
            sum += b;
            tx_q.push_back(b);
        end
        tx_q.push_back(kind == FRAME_BAD_SUM ? sum + 8'($urandom_range(1, 255)) : sum);
        tx_q.push_back(kind == FRAME_BAD_TAIL ? cur_tail ^ 8'($urandom_range(1, 255))
                                              : cur_tail);
        if (kind == FRAME_CUT)
            repeat ($urandom_range(1, len - 1)) void'(tx_q.pop_back());
    endfunction

    // Mostly short frames, a few up to the buffer size
    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(13, MAX_FRAME);
        return $urandom_range(MIN_LEN, 12);
    endfunction

    // Drive one byte transaction; hold it until accepted
    task automatic send_byte(logic [BYTE_W-1:0] b);
        int gap;
        gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall !== 1'b0);
        frame_chk.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_queue();
        while (tx_q.size() > 0)
            send_byte(tx_q.pop_front());
    endtask

    // Idle the sender until every predicted result is out, then let the block settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (frame_chk.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        frame_chk.set_reg(idx, data);
        if (idx == REG_HEAD)
            cur_head = data;
        else if (idx == REG_TAIL)
            cur_tail = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mix well-formed frames with corrupted ones and noise
    task automatic run_random(int count);
        int stop_at;
        int pick;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                add_frame(pick_len(), FRAME_GOOD, 1'b0);
            end else if (pick < 70) begin
                add_frame(pick_len(), FRAME_BAD_SUM, 1'b0);
            end else if (pick < 78) begin
                add_frame(pick_len(), FRAME_BAD_TAIL, 1'b0);
            end else if (pick < 85) begin
                add_frame(pick_len(), FRAME_CUT, 1'b0);
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 4)) tx_q.push_back(8'($urandom));
            end else begin
                tx_q.push_back(cur_head);
                tx_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, MIN_LEN - 1))
                                                    : 8'($urandom_range(MAX_FRAME + 1, 255)));
            end
            send_queue();
        end
    endtask

    // Accept result transactions with random stall
    initial begin : collect_results
        int hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            hold = (out_stall_max == 0) ? 0 : $urandom_range(0, out_stall_max);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (out_valid !== 1'b1);
            frame_chk.check_result({out_byte, out_index, out_last, out_status});
        end
    end

    // Bound the run
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        frame_chk = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_HEAD;
        cfg_data  <= '0;
        in_gap_max    = 11;
        out_stall_max = 11;
        bytes_sent    = 0;
        cur_head      = HEAD_RESET;
        cur_tail      = TAIL_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Good frame with all-zero and all-one bytes, then a checksum error
        add_frame(7, FRAME_GOOD, 1'b1);
        add_frame(MIN_LEN, FRAME_BAD_SUM, 1'b0);
        // Heads whose length is just out of range on either side
        tx_q.push_back(cur_head);
        tx_q.push_back(8'(MIN_LEN - 1));
        tx_q.push_back(cur_head);
        tx_q.push_back(8'(MAX_FRAME + 1));
        // Wrong-tail outer frame hiding two frames that come out in one step
        tx_q.push_back(cur_head);
        tx_q.push_back(8'd13);
        add_frame(MIN_LEN, FRAME_GOOD, 1'b0);
        add_frame(MIN_LEN, FRAME_GOOD, 1'b0);
        tx_q.push_back(8'($urandom));
        tx_q.push_back(~cur_tail);
        send_queue();
        drain_results();

        // Reset settings
        add_frame(MAX_FRAME, FRAME_GOOD, 1'b0);
        send_queue();
        run_random(80);

        // Extreme settings, no idling on either side
        drain_results();
        write_cfg(REG_HEAD, 8'h00);
        write_cfg(REG_TAIL, 8'hFF);
        in_gap_max    = 0;
        out_stall_max = 0;
        run_random(80);

        // Opposite extremes, plus writes to unmapped indexes
        drain_results();
        write_cfg(REG_HEAD, 8'hFF);
        write_cfg(REG_TAIL, 8'h00);
        write_cfg(CFG_SPARE_LO, 8'($urandom));
        write_cfg(CFG_SPARE_HI, 8'($urandom));
        in_gap_max    = 11;
        out_stall_max = 11;
        run_random(80);

        // Random settings, fast sender
        drain_results();
        write_cfg(REG_HEAD, 8'($urandom));
        write_cfg(REG_TAIL, 8'($urandom));
        in_gap_max    = 3;
        out_stall_max = 11;
        run_random(60);

        // Back to the reset values, slow sender
        drain_results();
        write_cfg(REG_HEAD, HEAD_RESET);
        write_cfg(REG_TAIL, TAIL_RESET);
        in_gap_max    = 11;
        out_stall_max = 3;
        run_random(60);

        drain_results();
        if (frame_chk.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/ldf_pkg.sv
rtl/core/ldf_front.sv
rtl/core/ldf_scan.sv
rtl/core/ldf_out.sv
rtl/core/length_framed_byte_deframer.sv
verif/length_framed_byte_deframer_tb.sv
